### src/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the banker's safety check block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int OP_W       = 2;
  localparam int PID_W      = 4;
  localparam int RID_W      = 3;
  localparam int UNITS_W    = 8;
  localparam int NEED_W     = UNITS_W + 1;
  localparam int AVAIL_W    = 13;
  localparam int NP_CFG_W   = 5;
  localparam int NR_CFG_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_MAX_RESOURCES = 8;

  localparam logic [NP_CFG_W-1:0] NP_RESET = NP_CFG_W'(16);
  localparam logic [NR_CFG_W-1:0] NR_RESET = NR_CFG_W'(8);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_ENTRY = 2'd0,
    OP_LOAD_AVAIL = 2'd1,
    OP_RUN_CHECK  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_PROCESSES = 1'b0,
    REG_NUM_RESOURCES = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_REL_RD,
    ST_REL_ADD,
    ST_NEXT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

### src/bsc_if.sv
// ----------------------------------------------------------------------------
// bsc_if
// Valid/ready channels for command words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_in_if;
  import bsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [PID_W-1:0]   process_index;
  logic [RID_W-1:0]   resource_index;
  logic [UNITS_W-1:0] allocated_units;
  logic [UNITS_W-1:0] maximum_units;
  logic [UNITS_W-1:0] available_units;

  modport source (
    output valid, operation, process_index, resource_index,
           allocated_units, maximum_units, available_units,
    input  ready
  );

  modport sink (
    input  valid, operation, process_index, resource_index,
           allocated_units, maximum_units, available_units,
    output ready
  );
endinterface

interface bsc_out_if;
  import bsc_pkg::*;

  logic             valid;
  logic             ready;
  logic             is_safe;
  logic [PID_W-1:0] process_id;
  logic             last;

  modport source (
    output valid, is_safe, process_id, last,
    input  ready
  );

  modport sink (
    input  valid, is_safe, process_id, last,
    output ready
  );
endinterface

`default_nettype wire

### src/bankers_safety_check.sv
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm safety check over loaded allocation/maximum tables.
// ----------------------------------------------------------------------------
// Load words (matrix entry, available count) are written as they are accepted
// in the idle state. A check word runs a sequencer over one shared compare/add
// unit and one read port of the entry memories: per visited process, read and
// compare states per resource compared plus a step state (a process already
// finished takes its read and step states only), and read and add states per
// resource when the process is released. Result words go out one per cycle
// while out_o.ready is high. The block takes no new word until the last result
// word of a check has been taken. Available counts carry over between checks.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_safety_check #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = bsc_pkg::DEF_MAX_RESOURCES
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bsc_in_if.sink                              in_i,
  bsc_out_if.source                           out_o
);
  import bsc_pkg::*;

  localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(MAX_PROCESSES);
  localparam int PCW   = $clog2(MAX_PROCESSES + 1);
  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int RCW   = $clog2(MAX_RESOURCES + 1);

  state_e state_q, state_d;

  logic [NP_CFG_W-1:0] cfg_np_q;
  logic [NR_CFG_W-1:0] cfg_nr_q;
  logic [PCW-1:0]      np;
  logic [RCW-1:0]      nr;

  logic [PW-1:0]            p_q;
  logic [PCW-1:0]           pass_q;
  logic [RW-1:0]            r_q;
  logic [PCW-1:0]           cnt_q;
  logic [PW-1:0]            k_q;
  logic                     safe_q;
  logic [MAX_PROCESSES-1:0] done_q;

  logic [AVAIL_W-1:0] avail_q [MAX_RESOURCES];
  logic [PID_W-1:0]   order_q [MAX_PROCESSES];

  logic [UNITS_W-1:0] alloc_mem [DEPTH];
  logic [NEED_W-1:0]  need_mem  [DEPTH];
  logic [UNITS_W-1:0] alloc_rd_q;
  logic [NEED_W-1:0]  need_rd_q;

  logic            in_hs, out_hs;
  op_e             op;
  logic            pi_ok, ri_ok;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_addr, load_addr, run_addr;
  logic [NEED_W-1:0] need_wr;
  logic            r_last, p_last, pass_last, k_last, all_done, need_ok;
  logic [AVAIL_W:0]   sum;
  logic [AVAIL_W-1:0] sum_sat;

  // clamped register counts
  always_comb begin
    if (cfg_np_q == '0) begin
      np = PCW'(1);
    end else if (int'(cfg_np_q) > MAX_PROCESSES) begin
      np = PCW'(MAX_PROCESSES);
    end else begin
      np = PCW'(cfg_np_q);
    end
    if (cfg_nr_q == '0) begin
      nr = RCW'(1);
    end else if (int'(cfg_nr_q) > MAX_RESOURCES) begin
      nr = RCW'(MAX_RESOURCES);
    end else begin
      nr = RCW'(cfg_nr_q);
    end
  end

  assign in_hs  = in_i.valid && in_i.ready;
  assign out_hs = out_o.valid && out_o.ready;
  assign op     = op_e'(in_i.operation);
  assign pi_ok  = int'(in_i.process_index) < MAX_PROCESSES;
  assign ri_ok  = int'(in_i.resource_index) < MAX_RESOURCES;

  assign load_addr = AW'(AW'(in_i.process_index) * AW'(MAX_RESOURCES))
                   + AW'(in_i.resource_index);
  assign run_addr  = AW'(AW'(p_q) * AW'(MAX_RESOURCES)) + AW'(r_q);
  assign need_wr   = {1'b0, in_i.maximum_units} - {1'b0, in_i.allocated_units};

  assign r_last    = RCW'(r_q) == RCW'(nr - RCW'(1));
  assign p_last    = PCW'(p_q) == PCW'(np - PCW'(1));
  assign pass_last = pass_q == PCW'(np - PCW'(1));
  assign k_last    = PCW'(k_q) == PCW'(np - PCW'(1));
  assign all_done  = cnt_q == np;

  // shared compare and saturating add
  assign need_ok = need_rd_q[NEED_W-1] ||
                   ({{(AVAIL_W-UNITS_W){1'b0}}, need_rd_q[UNITS_W-1:0]} <= avail_q[r_q]);
  assign sum     = {1'b0, avail_q[r_q]} + (AVAIL_W+1)'(alloc_rd_q);
  assign sum_sat = sum[AVAIL_W] ? {AVAIL_W{1'b1}} : sum[AVAIL_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_hs && op == OP_RUN_CHECK) state_d = ST_CHK_RD;
      end
      ST_CHK_RD: begin
        state_d = done_q[p_q] ? ST_NEXT : ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (!need_ok) begin
          state_d = ST_NEXT;
        end else if (r_last) begin
          state_d = ST_REL_RD;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_REL_RD: begin
        state_d = ST_REL_ADD;
      end
      ST_REL_ADD: begin
        state_d = r_last ? ST_NEXT : ST_REL_RD;
      end
      ST_NEXT: begin
        if (all_done || (p_last && pass_last)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_CHK_RD;
        end
      end
      ST_OUT: begin
        if (out_hs && (!safe_q || k_last)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_i.ready       = state_q == ST_IDLE;
    out_o.valid      = state_q == ST_OUT;
    out_o.is_safe    = safe_q;
    out_o.process_id = safe_q ? order_q[k_q] : '0;
    out_o.last       = !safe_q || k_last;
    mem_we           = in_hs && op == OP_LOAD_ENTRY && pi_ok && ri_ok;
    mem_re           = (state_q == ST_CHK_RD) || (state_q == ST_REL_RD);
    mem_addr         = (state_q == ST_IDLE) ? load_addr : run_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      alloc_mem[mem_addr] <= in_i.allocated_units;
      need_mem[mem_addr]  <= need_wr;
    end
    if (mem_re) begin
      alloc_rd_q <= alloc_mem[mem_addr];
      need_rd_q  <= need_mem[mem_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_np_q <= NP_RESET;
      cfg_nr_q <= NR_RESET;
      p_q      <= '0;
      pass_q   <= '0;
      r_q      <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      safe_q   <= 1'b0;
      done_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_NUM_PROCESSES: cfg_np_q <= NP_CFG_W'(cfg_data_i);
          REG_NUM_RESOURCES: cfg_nr_q <= NR_CFG_W'(cfg_data_i);
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_hs && op == OP_RUN_CHECK) begin
            p_q    <= '0;
            pass_q <= '0;
            r_q    <= '0;
            cnt_q  <= '0;
            k_q    <= '0;
            done_q <= '0;
          end
        end
        ST_CHK_CMP: begin
          r_q <= (!need_ok || r_last) ? '0 : RW'(r_q + RW'(1));
        end
        ST_REL_ADD: begin
          if (r_last) begin
            r_q         <= '0;
            done_q[p_q] <= 1'b1;
            cnt_q       <= PCW'(cnt_q + PCW'(1));
          end else begin
            r_q <= RW'(r_q + RW'(1));
          end
        end
        ST_NEXT: begin
          safe_q <= all_done;
          if (p_last) begin
            p_q    <= '0;
            pass_q <= PCW'(pass_q + PCW'(1));
          end else begin
            p_q <= PW'(p_q + PW'(1));
          end
        end
        ST_OUT: begin
          if (out_hs) k_q <= PW'(k_q + PW'(1));
        end
        default: ;
      endcase
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    if (in_hs && op == OP_LOAD_AVAIL && ri_ok) begin
      avail_q[RW'(in_i.resource_index)] <=
        {{(AVAIL_W-UNITS_W){1'b0}}, in_i.available_units};
    end
    if (state_q == ST_REL_ADD) begin
      avail_q[r_q] <= sum_sat;
      if (r_last) order_q[cnt_q[PW-1:0]] <= PID_W'(p_q);
    end
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while results pending");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && op == OP_RUN_CHECK) |=> !in_i.ready)
    else $error("check word did not start a run");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q <= np))
    else $error("finished count above process count");

  a_unsafe_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_safe) |-> (out_o.last && out_o.process_id == '0))
    else $error("unsafe word malformed");

  a_safe_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_safe) |-> all_done)
    else $error("safe word without all processes finished");
`endif

endmodule

`default_nettype wire
